// ===== rtl/nearest_point_search_defines.svh =====
// Assertion macros for the nearest point search block.
// Included by the top level; no other dependencies.
`ifndef NEAREST_POINT_SEARCH_DEFINES_SVH
`define NEAREST_POINT_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define NPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("nearest_point_search assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define NPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("nearest_point_search assertion failed");
`else
`define NPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/nps_pkg.sv =====
// Shared types, codes and helpers for the nearest point search block.
// Used by every module in the rtl folder; has no dependencies.
package nps_pkg;

	localparam int COORD_BITS = 20;
	localparam int LIM_W      = 20;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int DIST_W     = 2 * DIFF_W;
	localparam int IDX_OUT_W  = 6;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_PRI    = 2'd2;
	localparam logic [1:0] CMD_EXT    = 2'd3;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16000);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic [DIST_W-1:0]            dist_t;
	typedef logic [LIM_W-1:0]             lim_t;

	typedef struct packed {
		logic [1:0] cmd;
		coord_t     pos_x;
		coord_t     pos_y;
		coord_t     pos_z;
		coord_t     ext_x;
		coord_t     ext_y;
		coord_t     ext_z;
	} req_item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] index;
		logic                 found;
		logic [1:0]           status;
	} res_item_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		point_t pri;
		point_t ext;
	} entry_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} vec_t;

	// Tag that travels with each operand set through the table read and the distance unit.
	typedef struct packed {
		logic valid;
		logic last;
		logic is_lim;
	} scan_tag_t;

	function automatic diff_t sext(input coord_t v);
		return {v[COORD_BITS-1], v};
	endfunction

endpackage

// ===== rtl/nps_table.sv =====
// Entry table: one write port for appends and one registered read port for the scan.
// Depends on nps_pkg for the entry and tag types.
module nps_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  nps_pkg::entry_t   wr_data,
	input  nps_pkg::scan_tag_t rd_tag,
	input  logic [AW-1:0]     rd_addr,
	output nps_pkg::entry_t   rd_data,
	output nps_pkg::scan_tag_t rd_tag_q,
	output logic [AW-1:0]     rd_idx_q
);
	import nps_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
		rd_idx_q  <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_q <= '0;
		end else begin
			rd_tag_q <= rd_tag;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/nps_dist.sv =====
// Pipelined squared-distance unit: difference, square and sum in three stages.
// Depends on nps_pkg for the vector, distance and tag types.
module nps_dist #(
	parameter int IDX_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nps_pkg::scan_tag_t in_tag,
	input  logic [IDX_W-1:0]   in_idx,
	input  nps_pkg::vec_t      a,
	input  nps_pkg::vec_t      b,
	output nps_pkg::scan_tag_t out_tag,
	output logic [IDX_W-1:0]   out_idx,
	output nps_pkg::dist_t     dist_sum
);
	import nps_pkg::*;

	vec_t       d_s1;
	dist_t      sq_x_s2, sq_y_s2, sq_z_s2;
	dist_t      dist_s3;
	scan_tag_t  tag_s1, tag_s2, tag_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [DIST_W-1:0] p_x, p_y, p_z;

	// Callers keep every difference inside DIFF_W bits, so the truncation is exact.
	assign p_x = d_s1.x * d_s1.x;
	assign p_y = d_s1.y * d_s1.y;
	assign p_z = d_s1.z * d_s1.z;

	always_ff @(posedge clk) begin
		d_s1.x  <= DIFF_W'(a.x - b.x);
		d_s1.y  <= DIFF_W'(a.y - b.y);
		d_s1.z  <= DIFF_W'(a.z - b.z);
		idx_s1  <= in_idx;
		sq_x_s2 <= dist_t'(unsigned'(p_x));
		sq_y_s2 <= dist_t'(unsigned'(p_y));
		sq_z_s2 <= dist_t'(unsigned'(p_z));
		idx_s2  <= idx_s1;
		// Three squares of at most 2^40 each cannot carry out of DIST_W bits.
		dist_s3 <= sq_x_s2 + sq_y_s2 + sq_z_s2;
		idx_s3  <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign out_tag  = tag_s3;
	assign out_idx  = idx_s3;
	assign dist_sum = dist_s3;

endmodule

// ===== rtl/nearest_point_search.sv =====
// Top level of the nearest point search block: sequencer, running minimum and result register.
// Depends on nps_pkg, nps_table, nps_dist and nearest_point_search_defines.svh.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_item (cmd and six coordinates)
//   res      out  res_valid/res_stall  res_item (index, found, status)
//   cfg      in   cfg_valid/cfg_ready  cfg_data (max_distance)
//
// Clear and append go from accept straight to the done state; a query issues one table
// read per cycle, feeding the three-stage distance unit, whose latency is paid once at
// the end of the scan.
// Reset clears the entry count, restores max_distance to 16000 and empties the result register.
// req_stall is high while an item is in work; a stalled result holds the block in its final
// state until it is taken, but a waiting result never blocks the accept of the next item.
`include "nearest_point_search_defines.svh"

module nearest_point_search #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  nps_pkg::req_item_t  req_item,
	output logic                res_valid,
	input  logic                res_stall,
	output nps_pkg::res_item_t  res_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  nps_pkg::lim_t       cfg_data
);
	import nps_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LIM   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] iss_q;
	lim_t          max_dist_q;
	coord_t        qx_q, qz_q, ext0_y_q;
	logic          sel_ext_q;
	dist_t         best_q;
	logic [AW-1:0] best_idx_q;
	logic          found_q;
	logic [1:0]    status_q;
	logic          res_valid_q;
	res_item_t     res_item_q;

	logic          req_acc;
	logic          out_free;
	logic          wr_en;
	entry_t        wr_data;
	scan_tag_t     rd_tag;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;
	scan_tag_t     tbl_tag;
	logic [AW-1:0] tbl_idx;
	point_t        pt;
	scan_tag_t     u_tag;
	logic [AW-1:0] u_idx;
	vec_t          u_a, u_b;
	scan_tag_t     d_tag;
	logic [AW-1:0] d_idx;
	dist_t         d_dist;
	logic          win;
	logic          is_last_iss;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// Table write on an accepted append that fits.
	assign wr_en       = req_acc && (req_item.cmd == CMD_APPEND) &&
			(count_q != CW'(MAX_ENTRIES));
	assign wr_data.pri = '{x: req_item.pos_x, y: req_item.pos_y, z: req_item.pos_z};
	assign wr_data.ext = '{x: req_item.ext_x, y: req_item.ext_y, z: req_item.ext_z};

	assign is_last_iss = (CW'(iss_q) == count_q - CW'(1));

	always_comb begin
		rd_tag  = '0;
		rd_addr = iss_q;
		case (state_q)
			ST_LIM: begin
				rd_addr     = '0;
				rd_tag.valid = 1'b1;
				rd_tag.last  = (count_q == CW'(1));
			end
			ST_SCAN: begin
				rd_tag.valid = 1'b1;
				rd_tag.last  = is_last_iss;
			end
			default: begin
				rd_tag = '0;
			end
		endcase
	end

	nps_table #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (count_q[AW-1:0]),
		.wr_data  (wr_data),
		.rd_tag   (rd_tag),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.rd_tag_q (tbl_tag),
		.rd_idx_q (tbl_idx)
	);

	// The limit goes through the distance unit as (lim, 0, 0) ahead of the first entry,
	// so the running minimum starts at max_distance squared.
	assign pt = sel_ext_q ? rd_data.ext : rd_data.pri;

	always_comb begin
		if (state_q == ST_LIM) begin
			u_tag = '{valid: 1'b1, last: 1'b0, is_lim: 1'b1};
			u_idx = '0;
			u_a   = '{x: $signed({1'b0, max_dist_q}), y: '0, z: '0};
			u_b   = '0;
		end else begin
			u_tag = tbl_tag;
			u_idx = tbl_idx;
			u_a   = '{x: sext(pt.x), y: sext(pt.y), z: sext(pt.z)};
			u_b   = '{x: sext(qx_q), y: sext(ext0_y_q), z: sext(qz_q)};
		end
	end

	nps_dist #(
		.IDX_W (AW)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (u_tag),
		.in_idx   (u_idx),
		.a        (u_a),
		.b        (u_b),
		.out_tag  (d_tag),
		.out_idx  (d_idx),
		.dist_sum (d_dist)
	);

	// Strictly smaller wins, so the first of equal minima is kept.
	assign win = d_tag.valid && !d_tag.is_lim && (d_dist < best_q);

	always_ff @(posedge clk) begin
		if (req_acc) begin
			qx_q      <= req_item.pos_x;
			qz_q      <= req_item.pos_z;
			sel_ext_q <= (req_item.cmd == CMD_EXT);
		end
		if (wr_en && (count_q == '0)) begin
			ext0_y_q <= req_item.ext_y;
		end
		if (d_tag.valid && d_tag.is_lim) begin
			best_q <= d_dist;
		end else if (win) begin
			best_q <= d_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			iss_q       <= '0;
			max_dist_q  <= LIM_RESET;
			best_idx_q  <= '0;
			found_q     <= 1'b0;
			status_q    <= STS_OK;
			res_valid_q <= 1'b0;
			res_item_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_dist_q <= cfg_data;
			end
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (win) begin
				best_idx_q <= d_idx;
				found_q    <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						best_idx_q <= '0;
						found_q    <= 1'b0;
						iss_q      <= '0;
						case (req_item.cmd)
							CMD_CLEAR: begin
								count_q  <= '0;
								status_q <= STS_OK;
								state_q  <= ST_DONE;
							end
							CMD_APPEND: begin
								state_q <= ST_DONE;
								if (count_q == CW'(MAX_ENTRIES)) begin
									status_q <= STS_FULL;
								end else begin
									status_q <= STS_OK;
									count_q  <= count_q + CW'(1);
								end
							end
							default: begin
								if (count_q == '0) begin
									status_q <= STS_EMPTY;
									state_q  <= ST_DONE;
								end else begin
									status_q <= STS_OK;
									state_q  <= ST_LIM;
								end
							end
						endcase
					end
				end
				ST_LIM: begin
					iss_q   <= AW'(1);
					state_q <= (count_q == CW'(1)) ? ST_DRAIN : ST_SCAN;
				end
				ST_SCAN: begin
					iss_q <= iss_q + AW'(1);
					if (is_last_iss) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (d_tag.valid && d_tag.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_item_q.index  <= IDX_OUT_W'(best_idx_q);
						res_item_q.found  <= found_q;
						res_item_q.status <= status_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`NPS_ASSERT_IMP(a_dist_only_in_scan, clk, arst_n, d_tag.valid,
			(state_q == ST_SCAN) || (state_q == ST_DRAIN))
	`NPS_ASSERT_IMP(a_found_means_ok, clk, arst_n, res_valid && res_item.found,
			res_item.status == STS_OK)
	`NPS_ASSERT_IMP(a_count_in_range, clk, arst_n, 1'b1, count_q <= CW'(MAX_ENTRIES))
	`NPS_ASSERT_NXT(a_last_ends_scan, clk, arst_n,
			(state_q == ST_DRAIN) && d_tag.valid && d_tag.last, state_q == ST_DONE)

endmodule
